### hdl/b2da_pkg.sv
// Shared widths, character codes, and control structs for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int WORD_BITS   = 32;
  // Decimal digits needed for the largest unsigned word: floor(WORD_BITS * log10(2)) + 1.
  localparam int DIGITS      = (WORD_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS    = 4 * DIGITS;
  localparam int BIT_CNT_W   = $clog2(WORD_BITS + 1);
  localparam int DIG_CNT_W   = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BCD_BITS-1:0]  bcd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // input side may accept a beat
    logic dabble;      // one shift-add-3 step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // place '-' in the output register
    logic emit_digit;  // place the top digit in the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic neg;
    logic bit_last;
    logic top_zero;
    logic dig_last;
    logic out_free;
  } status_t;

  // Double dabble correction of one BCD digit before the shift.
  function automatic logic [3:0] add3(input logic [3:0] digit);
    logic [3:0] res;
    res = (digit >= 4'd5) ? (digit + 4'd3) : digit;
    return res;
  endfunction

endpackage

### hdl/b2da_intf.sv
// Valid/ready channel interfaces for words in, characters out, and the mode register.
interface b2da_word_if;
  logic               valid;
  logic               ready;
  b2da_pkg::word_t    value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

interface b2da_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b2da_cfg_if;
  logic valid;
  logic ready;
  logic signed_mode;
  modport source (output valid, output signed_mode, input ready);
  modport sink   (input valid, input signed_mode, output ready);
endinterface

### hdl/b2da_dp.sv
// Datapath: mode register, magnitude and BCD shift registers, counters, and output register.
module b2da_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b2da_pkg::cmd_t      cmd_i,
  output b2da_pkg::status_t   status_o,
  b2da_word_if.sink           value_i,
  b2da_char_if.source         char_o,
  b2da_cfg_if.sink            cfg_i
);

  logic                            signed_mode_q;
  b2da_pkg::word_t                 mag_q, mag_d;
  b2da_pkg::bcd_t                  bcd_q, bcd_adj;
  logic                            neg_q, neg_d;
  logic [b2da_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
  logic [b2da_pkg::DIG_CNT_W-1:0]  dig_cnt_q;
  logic                            out_valid_q;
  logic [7:0]                      char_q;
  logic                            last_q;
  logic [3:0]                      top_digit;
  logic                            load;
  logic                            out_free;

  assign cfg_i.ready   = 1'b1;
  assign value_i.ready = cmd_i.take;
  assign load          = cmd_i.take && value_i.valid;

  assign neg_d = signed_mode_q && value_i.value_bits[b2da_pkg::WORD_BITS-1];
  assign mag_d = neg_d ? (~value_i.value_bits + {{(b2da_pkg::WORD_BITS-1){1'b0}}, 1'b1})
                       : value_i.value_bits;

  always_comb begin
    for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
      bcd_adj[4*i +: 4] = b2da_pkg::add3(bcd_q[4*i +: 4]);
    end
  end

  assign top_digit = bcd_q[b2da_pkg::BCD_BITS-1 -: 4];
  assign out_free  = !out_valid_q || char_o.ready;

  assign status_o.in_valid = value_i.valid;
  assign status_o.neg      = neg_q;
  assign status_o.bit_last = (bit_cnt_q == b2da_pkg::BIT_CNT_W'(1));
  assign status_o.top_zero = (top_digit == 4'd0);
  assign status_o.dig_last = (dig_cnt_q == b2da_pkg::DIG_CNT_W'(1));
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b1;
      bit_cnt_q     <= '0;
      dig_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        signed_mode_q <= cfg_i.signed_mode;
      end
      if (load) begin
        bit_cnt_q <= b2da_pkg::BIT_CNT_W'(b2da_pkg::WORD_BITS);
        dig_cnt_q <= b2da_pkg::DIG_CNT_W'(b2da_pkg::DIGITS);
      end else if (cmd_i.dabble) begin
        bit_cnt_q <= bit_cnt_q - b2da_pkg::BIT_CNT_W'(1);
      end else if (cmd_i.skip || cmd_i.emit_digit) begin
        dig_cnt_q <= dig_cnt_q - b2da_pkg::DIG_CNT_W'(1);
      end
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (char_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      bcd_q <= '0;
    end else if (cmd_i.dabble) begin
      mag_q <= {mag_q[b2da_pkg::WORD_BITS-2:0], 1'b0};
      bcd_q <= {bcd_adj[b2da_pkg::BCD_BITS-2:0], mag_q[b2da_pkg::WORD_BITS-1]};
    end else if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_q <= {bcd_q[b2da_pkg::BCD_BITS-5:0], 4'd0};
    end
    if (cmd_i.emit_sign) begin
      char_q <= b2da_pkg::CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= b2da_pkg::CHAR_ZERO + {4'd0, top_digit};
      last_q <= status_o.dig_last;
    end
  end

  assign char_o.valid     = out_valid_q;
  assign char_o.char_code = char_q;
  assign char_o.last_char = last_q;

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_sign || cmd_i.emit_digit) |-> out_free)
    else $error("character placed while the output register is occupied");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> (top_digit <= 4'd9))
    else $error("emitted BCD digit is not decimal");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_digit || cmd_i.skip) |-> (dig_cnt_q != '0))
    else $error("digit counter exhausted");
`endif

endmodule

### hdl/b2da_ctrl.sv
// Controller: sequences load, conversion, leading zero removal, and character emission.
module b2da_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b2da_pkg::status_t   status_i,
  output b2da_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = 1'b1;
        if (status_i.in_valid) begin
          state_d = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd_o.dabble = 1'b1;
        if (status_i.bit_last) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // A lone zero digit is kept so that zero prints as "0".
        if (status_i.top_zero && !status_i.dig_last) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = status_i.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.dig_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take, cmd_o.dabble, cmd_o.skip, cmd_o.emit_sign, cmd_o.emit_digit}))
    else $error("more than one datapath command at once");

  a_convert_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP && $past(state_q) == ST_CONVERT) |-> $past(status_i.bit_last))
    else $error("conversion left before all bits were shifted");
`endif

endmodule

### hdl/binary_to_decimal_ascii_core.sv
// Top level of the binary to decimal ASCII converter.
//
//   Channel   Dir   Payload                       Beat
//   value_i   in    value_bits[31:0]              one word to convert
//   char_o    out   char_code[7:0], last_char     one ASCII character
//   cfg_i     in    signed_mode                   write of the mode register
//
// A word is accepted, converted by double dabble a bit at a time, stripped of its
// leading zero digits but the last, then emitted as an optional '-' and its digits.
// A new word is accepted only in the idle state, which follows the last digit;
// the output register lets the last character wait while the next word enters.
// Output back-pressure holds the sequencer in its emit states.
// Reset sets signed mode and clears the sequencer and the output valid.
module binary_to_decimal_ascii_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  b2da_word_if.sink    value_i,
  b2da_char_if.source  char_o,
  b2da_cfg_if.sink     cfg_i
);

  b2da_pkg::cmd_t    cmd;
  b2da_pkg::status_t status;

  b2da_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  b2da_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .value_i  (value_i),
    .char_o   (char_o),
    .cfg_i    (cfg_i)
  );

endmodule

### tb/b2da_text_board_pkg.sv
// Scoreboard that predicts and checks the decimal text produced for each accepted word.
`timescale 1ns / 100ps
package b2da_text_board_pkg;
  import b2da_pkg::*;

  class decimal_text_board;
    typedef struct packed {
      logic [7:0] code;
      logic       last;
    } char_beat_t;

    bit         signed_mode;
    char_beat_t expected_chars[$];
    int         failures;

    function new();
      signed_mode = 1'b1;
      failures    = 0;
    endfunction

    function void set_mode(bit mode);
      signed_mode = mode;
    endfunction

    // Queues the characters of one word: optional sign, then digits from the most significant.
    function void note_word(word_t word);
      word_t      mag;
      bit         neg;
      logic [7:0] digits[$];
      char_beat_t beat;
      neg = signed_mode && word[WORD_BITS-1];
      // The negation wraps at the word width, so the most negative value keeps its magnitude.
      mag = neg ? word_t'(~word + 1'b1) : word;
      do begin
        digits.push_front(CHAR_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        beat.code = CHAR_MINUS;
        beat.last = 1'b0;
        expected_chars.push_back(beat);
      end
      foreach (digits[i]) begin
        beat.code = digits[i];
        beat.last = (i == digits.size() - 1);
        expected_chars.push_back(beat);
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      char_beat_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code=%0d last_char=%0b", code, last);
        failures++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $error("char_code: expected %0d, got %0d", want.code, code);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_char: expected %0b, got %0b", want.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

endpackage

### tb/binary_to_decimal_ascii_core_test.sv
// Top-level testbench that drives words and mode writes and checks the emitted characters.
`timescale 1ns / 100ps
module binary_to_decimal_ascii_core_test;
  import b2da_pkg::*;
  import b2da_text_board_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_WORDS  = 45;

  logic clk_i;
  logic rst_ni;

  b2da_word_if value_if ();
  b2da_char_if char_if ();
  b2da_cfg_if  mode_if ();

  binary_to_decimal_ascii_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_if),
    .char_o  (char_if),
    .cfg_i   (mode_if)
  );

  decimal_text_board board = new();

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin : char_receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    char_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (!rst_ni) begin
        char_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        char_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        char_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        char_if.ready <= 1'b0;
      end else begin
        char_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && char_if.valid && char_if.ready) begin
      board.check_char(char_if.char_code, char_if.last_char);
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((value_if.valid && value_if.ready) || (char_if.valid && char_if.ready) ||
        (mode_if.valid && mode_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(word_t word);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      value_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    value_if.valid      <= 1'b1;
    value_if.value_bits <= word;
    do @(posedge clk_i); while (!value_if.ready);
    board.note_word(word);
  endtask

  // Lowers the word valid, then waits until every expected character has come out.
  task automatic drain_words();
    value_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(bit mode);
    mode_if.valid       <= 1'b1;
    mode_if.signed_mode <= mode;
    do @(posedge clk_i); while (!mode_if.ready);
    mode_if.valid <= 1'b0;
    board.set_mode(mode);
  endtask

  function automatic word_t pick_word();
    word_t pow10;
    word_t word;
    pow10 = 1;
    repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
    case ($urandom_range(0, 5))
      0: word = $urandom;
      1: word = $urandom_range(0, 99);
      2: word = pow10 + $urandom_range(0, 2) - 1;
      3: word = -word_t'($urandom_range(1, 1000));
      4: word = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: word = $urandom >> $urandom_range(0, 31);
    endcase
    return word;
  endfunction

  task automatic send_random(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_request = 1'b1;
      send_word(pick_word());
    end
  endtask

  initial begin
    tx_idle_on          = 1'b1;
    rx_idle_on          = 1'b1;
    hold_request        = 1'b0;
    quiet_cycles        = 0;
    rst_ni              <= 1'b0;
    value_if.valid      <= 1'b0;
    value_if.value_bits <= '0;
    mode_if.valid       <= 1'b0;
    mode_if.signed_mode <= 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset leaves signed mode on: zero, single digits, extremes and the most negative value.
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'd9);
    send_word(32'd10);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h8000_0001);
    send_word(32'hFFFF_FFFF);
    send_word(-32'd1000000000);
    send_word(32'd1000000000);
    send_word(32'd999999999);
    drain_words();

    write_mode(1'b0);
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'd4000000000);
    send_word(32'd1000000000);
    send_word(32'd7);
    send_word(32'd99999);
    send_word(32'd1234567890);
    drain_words();

    write_mode(1'b1);
    send_random(RANDOM_WORDS, 1'b1);
    drain_words();

    write_mode(1'b0);
    send_random(RANDOM_WORDS, 1'b0);
    drain_words();

    // The last part runs without idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_mode(1'b1);
    send_random(RANDOM_WORDS, 1'b0);
    drain_words();

    if (board.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
